// File: rtl/assert_macros.svh
// Assertion macros shared by the hash pipeline modules.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define SFH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that prop holds in the cycle after cond.
`define SFH_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: rtl/sfh_pkg.sv
// Types and hash step functions for the SuperFastHash stream block.
// Used by sfh_core, sfh_avalanche and superfasthash_stream; depends on nothing.
package sfh_pkg;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first;
		logic [31:0] msg_length;
		logic        last;
	} sfh_item_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] hash;
	} sfh_res_t;

	function automatic logic [31:0] sfh_sext8(input logic [7:0] b);
		return {{24{b[7]}}, b};
	endfunction

	// One full round over four bytes, block holds them little-endian.
	function automatic logic [31:0] sfh_round(input logic [31:0] h_in, input logic [31:0] blk);
		logic [31:0] h;
		logic [31:0] t;
		h = h_in + {16'b0, blk[15:0]};
		t = {5'b0, blk[31:16], 11'b0} ^ h;
		h = {h[15:0], 16'b0} ^ t;
		h = h + {11'b0, h[31:11]};
		return h;
	endfunction

	// Folds in the one to three leftover bytes; a count of zero leaves h alone.
	function automatic logic [31:0] sfh_tail(input logic [31:0] h_in, input logic [1:0] cnt,
			input logic [23:0] pb);
		logic [31:0] h;
		logic [31:0] s;
		h = h_in;
		s = '0;
		case (cnt)
			2'd3: begin
				s = sfh_sext8(pb[23:16]);
				h = h + {16'b0, pb[15:0]};
				h = h ^ {h[15:0], 16'b0};
				h = h ^ {s[13:0], 18'b0};
				h = h + {11'b0, h[31:11]};
			end
			2'd2: begin
				h = h + {16'b0, pb[15:0]};
				h = h ^ {h[20:0], 11'b0};
				h = h + {17'b0, h[31:17]};
			end
			2'd1: begin
				h = h + sfh_sext8(pb[7:0]);
				h = h ^ {h[21:0], 10'b0};
				h = h + {1'b0, h[31:1]};
			end
			default: begin
				h = h_in;
			end
		endcase
		return h;
	endfunction

	// First half of the final avalanche.
	function automatic logic [31:0] sfh_aval_a(input logic [31:0] h_in);
		logic [31:0] h;
		h = h_in ^ {h_in[28:0], 3'b0};
		h = h + {5'b0, h[31:5]};
		h = h ^ {h[27:0], 4'b0};
		return h;
	endfunction

	// Second half of the final avalanche.
	function automatic logic [31:0] sfh_aval_b(input logic [31:0] h_in);
		logic [31:0] h;
		h = h_in + {17'b0, h_in[31:17]};
		h = h ^ {h[6:0], 25'b0};
		h = h + {6'b0, h[31:6]};
		return h;
	endfunction

endpackage

// File: rtl/superfasthash_stream.sv
// superfasthash_stream: streaming 32-bit SuperFastHash, one message byte per transaction.
// Throughput is one transaction per cycle while in_stall is low; the result of a last byte
// (or of an empty message) is folded by the core behind the input register, held in
// stage 2, and gets one half of the avalanche on the way into stage 3 and the other
// on the way into the output register. Reset (arst_n, asynchronous, active low) closes
// any open message and empties the pipeline. Depends on sfh_pkg, sfh_core, sfh_avalanche.
module superfasthash_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first,
	input  logic [31:0] msg_length,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] hash_value
);
	import sfh_pkg::*;

	// The input register holds one transaction. It moves into the core
	// whenever the first result stage can take whatever it produces, so a
	// finished hash waiting in the output register does not block new bytes
	// until the whole pipeline behind it is full.
	logic      v_s1;
	sfh_item_t item_s1;
	logic      take;
	logic      fire;
	sfh_res_t  res;

	assign fire     = v_s1 && take;
	assign in_stall = v_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.data_byte  <= data_byte;
			item_s1.first      <= first;
			item_s1.msg_length <= msg_length;
			item_s1.last       <= last;
		end
	end

	// The core keeps the running hash and up to three pending bytes. It runs
	// a round on every fourth byte and, on the last byte, folds in the tail so
	// that only the avalanche remains for the result pipeline.
	sfh_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	// A stage register holds the pre-avalanche hash; the two halves of the avalanche
	// are registered into stage 3 and into the output register that faces the consumer.
	sfh_avalanche u_aval (
		.clk        (clk),
		.arst_n     (arst_n),
		.res        (res),
		.take       (take),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

endmodule

// File: rtl/sfh_core.sv
// Message state and byte gathering: runs rounds and the tail fold per byte.
// Depends on sfh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfh_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  sfh_pkg::sfh_item_t item,
	output sfh_pkg::sfh_res_t  res
);
	import sfh_pkg::*;

	logic [31:0] hash_q;
	logic [23:0] pend_q;
	logic [1:0]  cnt_q;
	logic        open_q;

	logic [31:0] hash_d;
	logic [23:0] pend_d;
	logic [1:0]  cnt_d;
	logic        open_d;

	logic [31:0] b_hash;
	logic [23:0] b_pend;
	logic [1:0]  b_cnt;
	logic        live;
	logic [31:0] m_hash;
	logic [23:0] m_pend;
	logic [1:0]  m_cnt;

	always_comb begin
		b_hash = hash_q;
		b_pend = pend_q;
		b_cnt  = cnt_q;
		live   = open_q;
		if (item.first) begin
			b_hash = item.msg_length;
			b_pend = '0;
			b_cnt  = '0;
			live   = (item.msg_length != 32'd0);
		end

		m_hash = b_hash;
		m_pend = b_pend;
		m_cnt  = b_cnt + 2'd1;
		case (b_cnt)
			2'd0: m_pend = {16'b0, item.data_byte};
			2'd1: m_pend = {8'b0, item.data_byte, b_pend[7:0]};
			2'd2: m_pend = {item.data_byte, b_pend[15:0]};
			default: begin
				m_hash = sfh_round(b_hash, {item.data_byte, b_pend});
				m_pend = '0;
				m_cnt  = 2'd0;
			end
		endcase

		hash_d     = hash_q;
		pend_d     = pend_q;
		cnt_d      = cnt_q;
		open_d     = open_q;
		res.valid  = 1'b0;
		res.hash   = '0;
		if (fire) begin
			if (item.first && !live) begin
				// Empty message: the hash is zero at once.
				res.valid = 1'b1;
				hash_d    = '0;
				pend_d    = '0;
				cnt_d     = '0;
				open_d    = 1'b0;
			end else if (live) begin
				if (item.last) begin
					res.valid = 1'b1;
					res.hash  = sfh_tail(m_hash, m_cnt, m_pend);
					hash_d    = '0;
					pend_d    = '0;
					cnt_d     = '0;
					open_d    = 1'b0;
				end else begin
					hash_d = m_hash;
					pend_d = m_pend;
					cnt_d  = m_cnt;
					open_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			pend_q <= '0;
			cnt_q  <= '0;
			open_q <= 1'b0;
		end else begin
			hash_q <= hash_d;
			pend_q <= pend_d;
			cnt_q  <= cnt_d;
			open_q <= open_d;
		end
	end

	`SFH_ASSERT_NEXT(a_last_closes, fire && item.last, !open_q && cnt_q == 2'd0,
		"message still open after last byte")
	`SFH_ASSERT(a_idle_empty, open_q || (cnt_q == 2'd0 && pend_q == 24'd0),
		"pending bytes held with no open message")
	`SFH_ASSERT_NEXT(a_first_opens,
		fire && item.first && !item.last && item.msg_length != 32'd0, open_q,
		"first byte did not open a message")

endmodule

// File: rtl/sfh_avalanche.sv
// Result pipeline: holds the pre-avalanche hash, applies the avalanche in
// two stages and drives the output register. Depends on sfh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfh_avalanche (
	input  logic             clk,
	input  logic             arst_n,
	input  sfh_pkg::sfh_res_t res,
	output logic             take,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [31:0]      hash_value
);
	import sfh_pkg::*;

	logic        v_s2;
	logic [31:0] h_s2;
	logic        v_s3;
	logic [31:0] h_s3;
	logic        out_valid_q;
	logic [31:0] hash_q;

	logic out_ready;
	logic s3_ready;

	assign out_ready = !out_valid_q || !out_stall;
	assign s3_ready  = !v_s3 || out_ready;
	assign take      = !v_s2 || s3_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				v_s2 <= res.valid;
			end
			if (s3_ready) begin
				v_s3 <= v_s2;
			end
			if (out_ready) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			h_s2 <= res.hash;
		end
		if (s3_ready) begin
			h_s3 <= sfh_aval_a(h_s2);
		end
		if (out_ready) begin
			hash_q <= sfh_aval_b(h_s3);
		end
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

	`SFH_ASSERT_NEXT(a_s3_holds, v_s3 && !s3_ready, v_s3 && $stable(h_s3),
		"stage 3 lost a held result")
	`SFH_ASSERT_NEXT(a_s2_holds, v_s2 && !take, v_s2 && $stable(h_s2),
		"stage 2 lost a held result")
	`SFH_ASSERT_NEXT(a_out_holds, out_valid_q && out_stall, out_valid_q && $stable(hash_q),
		"stalled output changed")

endmodule
